// File: hw/rtl/tkbmh_pkg.sv
// Package for the two-key binary min-heap: entry layout, status codes,
// operation codes and sequencer states. Depends on nothing.
package tkbmh_pkg;

   // Operation codes on the request channel.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // One heap entry: class is the first key, arrival time the second.
   typedef struct packed {
      logic [1:0]  cls;
      logic [31:0] arr_time;
      logic [15:0] handle;
   } tkbmh_entry_type;

   typedef enum logic [1:0] {
      STS_PUSHED = 2'd0,
      STS_FULL   = 2'd1,
      STS_POPPED = 2'd2,
      STS_EMPTY  = 2'd3
   } tkbmh_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_LAST,
      ST_POP_CAP,
      ST_DN_L,
      ST_DN_R,
      ST_DN_CMP,
      ST_DN_MOVE,
      ST_FIN,
      ST_RESP
   } tkbmh_state_type;

endpackage

// File: hw/rtl/two_key_binary_min_heap.sv
// Top level of the two-key binary min-heap priority queue.
// Depends on tkbmh_pkg and tkbmh_cmp.

// This block is a bounded min-heap of CAPACITY entries, each holding a
// priority class, an arrival time and an item handle; an entry with a lower
// class is served first, and within a class the earlier arrival time wins.
// Every request word produces exactly one response word carrying a status
// (pushed, full, popped or empty), the popped entry (zero unless popped) and
// the entry count after the operation. The block works on one request at a
// time and stalls the request channel until the response word has been taken.
// All key comparisons go through a single comparator, and the heap lives in a
// memory with one write port and one registered read port, so each heap level
// costs memory reads. A push accepts the request, reads and compares each
// parent in turn, writes the entry at the root when it climbs that far, and
// answers. A pop accepts the request, fetches the root and the last entry,
// reads and compares the children of each node it passes, writes the moved
// entry where it comes to rest, and answers. Full pushes and empty pops
// answer without touching the memory. The heap memory needs no clearing
// after reset, since only entries below the count are ever read.
module two_key_binary_min_heap #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [1:0]  req_priority_class,
   input  logic [31:0] req_arrival_time,
   input  logic [15:0] req_item_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_out_class,
   output logic [31:0] rsp_out_time,
   output logic [15:0] rsp_out_handle,
   output logic [6:0]  rsp_entry_count
);
   import tkbmh_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Heap storage, undefined until written.
   tkbmh_entry_type heap_mem_ff [CAPACITY];

   tkbmh_state_type  state_ff, state_in;
   logic [CW-1:0]    occ_ff, occ_in;
   logic [AW-1:0]    pos_ff, pos_in;
   tkbmh_entry_type  carry_ff, carry_in;
   tkbmh_entry_type  best_ff, best_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic             best_child_ff, best_child_in;
   tkbmh_status_type status_ff, status_in;
   tkbmh_entry_type  out_ff, out_in;
   tkbmh_entry_type  rd_data_ff;

   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   tkbmh_entry_type  wr_data;

   tkbmh_entry_type  cmp_a, cmp_b;
   logic             cmp_ahead;

   tkbmh_entry_type  req_entry;
   logic [AW-1:0]    pos_dec;
   logic [AW-1:0]    parent_idx;
   logic [AW+1:0]    left_idx;
   logic [AW+1:0]    right_idx;
   logic [AW+1:0]    occ_wide;
   logic [CW+6:0]    cnt_wide;

   assign req_entry.cls      = req_priority_class;
   assign req_entry.arr_time = req_arrival_time;
   assign req_entry.handle   = req_item_handle;

   // Index arithmetic for the current hole position.
   assign pos_dec    = pos_ff - AW'(1);
   assign parent_idx = pos_dec >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + (AW + 2)'(1);
   assign occ_wide   = (AW + 2)'(occ_ff);

   tkbmh_cmp u_cmp (
      .a       (cmp_a),
      .b       (cmp_b),
      .a_ahead (cmp_ahead)
   );

   // Comparator operand selection: the moving entry against a parent on the
   // way up, and each child against the best so far on the way down.
   always_comb begin
      unique case (state_ff)
         ST_UP_CMP: begin
            cmp_a = carry_ff;
            cmp_b = rd_data_ff;
         end
         ST_DN_CMP: begin
            cmp_a = rd_data_ff;
            cmp_b = best_ff;
         end
         default: begin
            cmp_a = rd_data_ff;
            cmp_b = carry_ff;
         end
      endcase
   end

   // The sequencer works with a hole: the moving entry waits in carry_ff and
   // is written only once its final place is known, while the entries it
   // passes are written into the hole one level at a time.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_child_in = best_child_ff;
      status_in     = status_ff;
      out_in        = out_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = carry_ff;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               out_in = '0;
               if (req_operation == OP_PUSH) begin
                  if (occ_ff == CW'(CAPACITY)) begin
                     status_in = STS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     status_in = STS_PUSHED;
                     carry_in  = req_entry;
                     pos_in    = AW'(occ_ff);
                     occ_in    = occ_ff + CW'(1);
                     state_in  = (occ_ff == '0) ? ST_FIN : ST_UP_RD;
                  end
               end else begin
                  if (occ_ff == '0) begin
                     status_in = STS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     // Read the root now; the count drops at once so that the
                     // last entry sits at the new count.
                     status_in = STS_POPPED;
                     occ_in    = occ_ff - CW'(1);
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     state_in  = ST_POP_LAST;
                  end
               end
            end
         end
         ST_UP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = parent_idx;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_ahead) begin
               wr_data  = rd_data_ff;
               pos_in   = parent_idx;
               state_in = (parent_idx == '0) ? ST_FIN : ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_POP_LAST: begin
            out_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = AW'(occ_ff);
            state_in = ST_POP_CAP;
         end
         ST_POP_CAP: begin
            carry_in = rd_data_ff;
            pos_in   = '0;
            state_in = ST_DN_L;
         end
         ST_DN_L: begin
            if (left_idx < occ_wide) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(left_idx);
               state_in = ST_DN_R;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DN_R: begin
            best_child_in = cmp_ahead;
            best_in       = cmp_ahead ? rd_data_ff : carry_ff;
            best_idx_in   = AW'(left_idx);
            if (right_idx < occ_wide) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(right_idx);
               state_in = ST_DN_CMP;
            end else begin
               state_in = ST_DN_MOVE;
            end
         end
         ST_DN_CMP: begin
            if (cmp_ahead) begin
               best_child_in = 1'b1;
               best_in       = rd_data_ff;
               best_idx_in   = AW'(right_idx);
            end
            state_in = ST_DN_MOVE;
         end
         ST_DN_MOVE: begin
            wr_en = 1'b1;
            if (best_child_ff) begin
               wr_data  = best_ff;
               pos_in   = best_idx_ff;
               state_in = ST_DN_L;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FIN: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      carry_ff      <= carry_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_child_ff <= best_child_in;
      status_ff     <= status_in;
      out_ff        <= out_in;
   end

   // Heap memory: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= heap_mem_ff[rd_addr];
      end
   end

   // The count field keeps the low seven bits of the occupancy.
   assign cnt_wide        = {7'b0, occ_ff};
   assign rsp_entry_count = cnt_wide[6:0];
   assign rsp_status      = status_ff;
   assign rsp_out_class   = out_ff.cls;
   assign rsp_out_time    = out_ff.arr_time;
   assign rsp_out_handle  = out_ff.handle;

endmodule

// File: hw/rtl/tkbmh_cmp.sv
// Shared key comparator of the heap: class first, arrival time second.
// Depends on tkbmh_pkg.
module tkbmh_cmp (
   input  tkbmh_pkg::tkbmh_entry_type a,
   input  tkbmh_pkg::tkbmh_entry_type b,
   output logic                       a_ahead
);
   import tkbmh_pkg::*;

   // Strictly ahead only, so equal keys never move past each other.
   assign a_ahead = (a.cls != b.cls) ? (a.cls < b.cls) : (a.arr_time < b.arr_time);

endmodule
